// File: rtl/gas_pkg.sv
// Package for the grid A* search block: cell codes, command modes, and shared records.
// Used by gas_core and grid_astar_search. It has no dependencies.
package gas_pkg;

    // Internal coordinate width. Six bits cover every clamped grid size.
    localparam int COORD_W = 6;
    localparam int G_W     = 12;
    localparam int H_W     = 7;
    localparam int F_W     = 13;

    // Cell state codes, as stored in the work map and returned on reads.
    localparam logic [2:0] ST_EMPTY  = 3'd0;
    localparam logic [2:0] ST_OBST   = 3'd1;
    localparam logic [2:0] ST_CLOSED = 3'd2;
    localparam logic [2:0] ST_PATH   = 3'd3;
    localparam logic [2:0] ST_START  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_GRID_ROWS = 3'd0;
    localparam logic [2:0] REG_GRID_COLS = 3'd1;
    localparam logic [2:0] REG_START_ROW = 3'd2;
    localparam logic [2:0] REG_START_COL = 3'd3;
    localparam logic [2:0] REG_GOAL_ROW  = 3'd4;
    localparam logic [2:0] REG_GOAL_COL  = 3'd5;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    // One input transfer after unpacking.
    typedef struct packed {
        mode_t      mode;
        logic [4:0] row;
        logic [4:0] col;
        logic       obstacle;
    } cmd_t;

    // Effective configuration; the grid size is already clamped.
    typedef struct packed {
        logic [COORD_W-1:0] rows;
        logic [COORD_W-1:0] cols;
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] goal_row;
        logic [COORD_W-1:0] goal_col;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [2:0] cell_state;
        logic       path_found;
        logic       searched;
    } res_t;

    // One open-list entry as kept in the open memory.
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [G_W-1:0]     g;
        logic [H_W-1:0]     h;
    } open_entry_t;

    localparam int OE_W = $bits(open_entry_t);

    // Manhattan distance between a cell and the goal.
    function automatic logic [H_W-1:0] manhattan(input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] c,
                                                 input logic [COORD_W-1:0] gr,
                                                 input logic [COORD_W-1:0] gc);
        logic [COORD_W-1:0] dr;
        logic [COORD_W-1:0] dc;
        dr = (r > gr) ? (r - gr) : (gr - r);
        dc = (c > gc) ? (c - gc) : (gc - c);
        return H_W'(dr) + H_W'(dc);
    endfunction

endpackage

// File: rtl/gas_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// It has no dependencies.
module gas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, plus a read port with registered read data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/gas_core.sv
// Search engine: obstacle, work and open-list memories with the sequencer that runs A*.
// Depends on gas_pkg and gas_ram.
module gas_core #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int OPEN_DEPTH = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  gas_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    input  gas_pkg::cmd_t cmd,
    output logic          idle,
    output logic          res_valid,
    output gas_pkg::res_t res
);
    import gas_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(OPEN_DEPTH);
    localparam int CNTW  = $clog2(OPEN_DEPTH + 1);
    localparam int SRW   = $clog2(MAX_ROWS + 1);
    localparam int SCW   = $clog2(MAX_COLS + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RDOUT, S_CLR, S_START, S_SCAN,
        S_POP, S_GOAL, S_FIN, S_NB, S_NBCHK
    } state_t;

    function automatic logic [AW-1:0] addr_of(input logic [COORD_W-1:0] r,
                                              input logic [COORD_W-1:0] c);
        return AW'(int'(r) * MAX_COLS + int'(c));
    endfunction

    state_t              state_reg, state_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [SRW-1:0]      srow_reg, srow_next;
    logic [SCW-1:0]      scol_reg, scol_next;
    logic                spend_reg, spend_next;
    logic                sin_reg, sin_next;
    logic [AW-1:0]       paddr_reg, paddr_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [CNTW-1:0]     sidx_reg, sidx_next;
    logic [IW-1:0]       spidx_reg, spidx_next;
    logic                any_reg, any_next;
    logic [F_W-1:0]      bestf_reg, bestf_next;
    logic [IW-1:0]       best_idx_reg, best_idx_next;
    open_entry_t         best_reg, best_next;
    open_entry_t         cur_reg, cur_next;
    logic [1:0]          nbk_reg, nbk_next;
    logic [COORD_W-1:0]  nb_row_reg, nb_row_next;
    logic [COORD_W-1:0]  nb_col_reg, nb_col_next;
    logic                rd_ok_reg, rd_ok_next;
    logic                found_reg, found_next;
    logic                done_reg, done_next;
    logic                res_valid_reg, res_valid_next;
    logic [2:0]          res_state_reg, res_state_next;

    logic                obst_we, obst_wdata, obst_rdata;
    logic [AW-1:0]       obst_waddr, obst_raddr;
    logic                work_we;
    logic [AW-1:0]       work_waddr, work_raddr;
    logic [2:0]          work_wdata, work_rdata;
    logic                open_we;
    logic [IW-1:0]       open_waddr, open_raddr;
    open_entry_t         open_wdata;
    logic [OE_W-1:0]     open_rdata;

    logic                scan_issue;
    logic                sweep_issue;
    open_entry_t         scan_e;
    logic [F_W-1:0]      scan_f;
    logic                nb_ok;
    logic [COORD_W-1:0]  nb_r, nb_c;

    gas_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obst_ram (
        .aclk(aclk), .we(obst_we), .waddr(obst_waddr), .wdata(obst_wdata),
        .raddr(obst_raddr), .rdata(obst_rdata)
    );

    gas_ram #(.WIDTH(3), .DEPTH(CELLS)) u_work_ram (
        .aclk(aclk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
        .raddr(work_raddr), .rdata(work_rdata)
    );

    gas_ram #(.WIDTH(OE_W), .DEPTH(OPEN_DEPTH)) u_open_ram (
        .aclk(aclk), .we(open_we), .waddr(open_waddr), .wdata(open_wdata),
        .raddr(open_raddr), .rdata(open_rdata)
    );

    assign idle      = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = '{cell_state: res_state_reg, path_found: found_reg, searched: done_reg};

    // Helpers for the sweep, the scan and the neighbor step.
    assign sweep_issue = int'(srow_reg) < MAX_ROWS;
    assign scan_issue  = sidx_reg < cnt_reg;
    assign scan_e      = open_entry_t'(open_rdata);
    assign scan_f      = F_W'(scan_e.g) + F_W'(scan_e.h);

    // Neighbors in the order up, left, down, right.
    always_comb begin
        nb_r  = cur_reg.row;
        nb_c  = cur_reg.col;
        nb_ok = 1'b0;
        unique case (nbk_reg)
            2'd0: begin
                nb_ok = cur_reg.row != '0;
                nb_r  = cur_reg.row - COORD_W'(1);
            end
            2'd1: begin
                nb_ok = cur_reg.col != '0;
                nb_c  = cur_reg.col - COORD_W'(1);
            end
            2'd2: begin
                nb_ok = int'(cur_reg.row) + 1 < int'(cfg.rows);
                nb_r  = cur_reg.row + COORD_W'(1);
            end
            default: begin
                nb_ok = int'(cur_reg.col) + 1 < int'(cfg.cols);
                nb_c  = cur_reg.col + COORD_W'(1);
            end
        endcase
    end

    // Sequencer: next state, memory controls and result.
    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        srow_next      = srow_reg;
        scol_next      = scol_reg;
        spend_next     = 1'b0;
        sin_next       = sin_reg;
        paddr_next     = paddr_reg;
        cnt_next       = cnt_reg;
        sidx_next      = sidx_reg;
        spidx_next     = spidx_reg;
        any_next       = any_reg;
        bestf_next     = bestf_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        cur_next       = cur_reg;
        nbk_next       = nbk_reg;
        nb_row_next    = nb_row_reg;
        nb_col_next    = nb_col_reg;
        rd_ok_next     = rd_ok_reg;
        found_next     = found_reg;
        done_next      = done_reg;
        res_valid_next = 1'b0;
        res_state_next = res_state_reg;

        obst_we    = 1'b0;
        obst_waddr = addr_reg;
        obst_wdata = 1'b0;
        obst_raddr = addr_reg;
        work_we    = 1'b0;
        work_waddr = paddr_reg;
        work_wdata = ST_EMPTY;
        work_raddr = addr_of(COORD_W'(cmd.row), COORD_W'(cmd.col));
        open_we    = 1'b0;
        open_waddr = cnt_reg[IW-1:0];
        open_wdata = '0;
        open_raddr = sidx_reg[IW-1:0];

        unique case (state_reg)
            // Clear the obstacle map after reset, one cell a cycle.
            S_INIT: begin
                obst_we   = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (int'(addr_reg) == CELLS - 1) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (cmd_valid) begin
                    res_state_next = ST_EMPTY;
                    unique case (cmd.mode)
                        MODE_WRITE: begin
                            obst_we        = (int'(cmd.row) < MAX_ROWS) &&
                                             (int'(cmd.col) < MAX_COLS);
                            obst_waddr     = addr_of(COORD_W'(cmd.row), COORD_W'(cmd.col));
                            obst_wdata     = cmd.obstacle;
                            res_valid_next = 1'b1;
                        end
                        MODE_SEARCH: begin
                            addr_next  = '0;
                            srow_next  = '0;
                            scol_next  = '0;
                            state_next = S_CLR;
                        end
                        MODE_READ: begin
                            rd_ok_next = found_reg &&
                                         (COORD_W'(cmd.row) < cfg.rows) &&
                                         (COORD_W'(cmd.col) < cfg.cols);
                            state_next = S_RDOUT;
                        end
                        default: begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            S_RDOUT: begin
                res_state_next = rd_ok_reg ? work_rdata : ST_EMPTY;
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            // Rebuild the work map over the whole memory: obstacle marks inside the grid in use, empty elsewhere.
            S_CLR: begin
                if (sweep_issue) begin
                    addr_next  = addr_reg + AW'(1);
                    spend_next = 1'b1;
                    paddr_next = addr_reg;
                    sin_next   = (int'(srow_reg) < int'(cfg.rows)) &&
                                 (int'(scol_reg) < int'(cfg.cols));
                    if (int'(scol_reg) == MAX_COLS - 1) begin
                        scol_next = '0;
                        srow_next = srow_reg + SRW'(1);
                    end else begin
                        scol_next = scol_reg + SCW'(1);
                    end
                end
                if (spend_reg) begin
                    work_we    = 1'b1;
                    work_wdata = (sin_reg && obst_rdata) ? ST_OBST : ST_EMPTY;
                end
                if (!sweep_issue && !spend_reg) begin
                    state_next = S_START;
                end
            end

            // Enter the start cell, or fail when it lies outside the grid.
            S_START: begin
                if ((cfg.start_row < cfg.rows) && (cfg.start_col < cfg.cols)) begin
                    open_we    = 1'b1;
                    open_waddr = '0;
                    open_wdata = '{valid: 1'b1, row: cfg.start_row, col: cfg.start_col,
                                   g: '0, h: manhattan(cfg.start_row, cfg.start_col,
                                                       cfg.goal_row, cfg.goal_col)};
                    work_we    = 1'b1;
                    work_waddr = addr_of(cfg.start_row, cfg.start_col);
                    work_wdata = ST_CLOSED;
                    cnt_next   = CNTW'(1);
                    sidx_next  = '0;
                    any_next   = 1'b0;
                    state_next = S_SCAN;
                end else begin
                    found_next     = 1'b0;
                    done_next      = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // Walk the open list; ties go to the later entry.
            S_SCAN: begin
                if (scan_issue) begin
                    sidx_next  = sidx_reg + CNTW'(1);
                    spend_next = 1'b1;
                    spidx_next = sidx_reg[IW-1:0];
                end
                if (spend_reg && scan_e.valid && (!any_reg || scan_f <= bestf_reg)) begin
                    any_next      = 1'b1;
                    bestf_next    = scan_f;
                    best_idx_next = spidx_reg;
                    best_next     = scan_e;
                end
                if (!scan_issue && !spend_reg) begin
                    if (any_reg) begin
                        state_next = S_POP;
                    end else begin
                        found_next     = 1'b0;
                        done_next      = 1'b1;
                        res_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end

            // Take the best entry out and mark its cell as path.
            S_POP: begin
                open_we    = 1'b1;
                open_waddr = best_idx_reg;
                open_wdata = '0;
                work_we    = 1'b1;
                work_waddr = addr_of(best_reg.row, best_reg.col);
                work_wdata = ST_PATH;
                cur_next   = best_reg;
                if ((best_reg.row == cfg.goal_row) && (best_reg.col == cfg.goal_col)) begin
                    state_next = S_GOAL;
                end else begin
                    nbk_next   = '0;
                    state_next = S_NB;
                end
            end

            S_GOAL: begin
                work_we    = 1'b1;
                work_waddr = addr_of(cfg.start_row, cfg.start_col);
                work_wdata = ST_START;
                state_next = S_FIN;
            end

            // The finish mark goes last so that it wins when goal equals start.
            S_FIN: begin
                work_we        = 1'b1;
                work_waddr     = addr_of(cfg.goal_row, cfg.goal_col);
                work_wdata     = ST_FINISH;
                found_next     = 1'b1;
                done_next      = 1'b1;
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            // Look up one neighbor in the work map.
            S_NB: begin
                work_raddr  = addr_of(nb_r, nb_c);
                nb_row_next = nb_r;
                nb_col_next = nb_c;
                if (nb_ok) begin
                    state_next = S_NBCHK;
                end else if (nbk_reg == 2'd3) begin
                    sidx_next  = '0;
                    any_next   = 1'b0;
                    state_next = S_SCAN;
                end else begin
                    nbk_next = nbk_reg + 2'd1;
                end
            end

            // Enter an empty neighbor while the open list has room.
            S_NBCHK: begin
                if ((work_rdata == ST_EMPTY) && (int'(cnt_reg) < OPEN_DEPTH)) begin
                    open_we    = 1'b1;
                    open_wdata = '{valid: 1'b1, row: nb_row_reg, col: nb_col_reg,
                                   g: cur_reg.g + G_W'(1),
                                   h: manhattan(nb_row_reg, nb_col_reg,
                                                cfg.goal_row, cfg.goal_col)};
                    work_we    = 1'b1;
                    work_waddr = addr_of(nb_row_reg, nb_col_reg);
                    work_wdata = ST_CLOSED;
                    cnt_next   = cnt_reg + CNTW'(1);
                end
                if (nbk_reg == 2'd3) begin
                    sidx_next  = '0;
                    any_next   = 1'b0;
                    state_next = S_SCAN;
                end else begin
                    nbk_next   = nbk_reg + 2'd1;
                    state_next = S_NB;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            addr_reg      <= '0;
            spend_reg     <= 1'b0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            spend_reg     <= spend_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
            res_valid_reg <= res_valid_next;
        end
        srow_reg      <= srow_next;
        scol_reg      <= scol_next;
        sin_reg       <= sin_next;
        paddr_reg     <= paddr_next;
        sidx_reg      <= sidx_next;
        spidx_reg     <= spidx_next;
        any_reg       <= any_next;
        bestf_reg     <= bestf_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        cur_reg       <= cur_next;
        nbk_reg       <= nbk_next;
        nb_row_reg    <= nb_row_next;
        nb_col_reg    <= nb_col_next;
        rd_ok_reg     <= rd_ok_next;
        res_state_reg <= res_state_next;
    end

    // A result is shown for one cycle and never twice in a row.
    a_res_single: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |=> !res_valid_reg)
        else $error("result valid held for two cycles");

    // The scan never runs past the filled part of the open list.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (sidx_reg <= cnt_reg))
        else $error("open-list scan beyond fill count");

    // A successful search ends with the done flag and a result.
    a_found_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(found_reg) |-> (done_reg && res_valid_reg))
        else $error("found flag set without completing a search");

    // Commands arrive only while the engine is idle.
    a_cmd_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid |-> idle)
        else $error("command taken while busy");

endmodule

// File: rtl/grid_astar_search.sv
// Grid A* search, top level: stream ports, configuration registers and result register.
// A cell write or a mode 3 item passes its result through the core's result register into the
// output register; a cell read first goes through the read-out state. A new transfer is taken
// only once the last result has left the core and the output register is free or being read.
// A search sweeps the whole obstacle map, then for each expansion scans the open list and
// checks up to four neighbors. Reset: configuration returns to its defaults, flags clear, then
// s_tready stays low while the obstacle memory is cleared. Depends on gas_pkg, gas_core.
module grid_astar_search #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int OPEN_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mode[1:0], cell_row[6:2], cell_col[11:7], obstacle[12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // cell_state[2:0], path_found[3], searched[4]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_wdata
);
    import gas_pkg::*;

    logic [5:0]  grid_rows_reg, grid_cols_reg;
    logic [4:0]  start_row_reg, start_col_reg, goal_row_reg, goal_col_reg;
    logic        m_tvalid_reg;
    res_t        m_res_reg;
    cfg_t        cfg;
    cmd_t        cmd;
    logic        cmd_valid;
    logic        core_idle;
    logic        res_valid;
    res_t        res;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= 6'd32;
            grid_cols_reg <= 6'd32;
            start_row_reg <= 5'd0;
            start_col_reg <= 5'd0;
            goal_row_reg  <= 5'd31;
            goal_col_reg  <= 5'd31;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_wdata;
                REG_GRID_COLS: grid_cols_reg <= cfg_wdata;
                REG_START_ROW: start_row_reg <= cfg_wdata[4:0];
                REG_START_COL: start_col_reg <= cfg_wdata[4:0];
                REG_GOAL_ROW:  goal_row_reg  <= cfg_wdata[4:0];
                REG_GOAL_COL:  goal_col_reg  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // Grid size clamped to the memory size.
    always_comb begin
        cfg.rows      = (int'(grid_rows_reg) > MAX_ROWS) ? COORD_W'(MAX_ROWS) : grid_rows_reg;
        cfg.cols      = (int'(grid_cols_reg) > MAX_COLS) ? COORD_W'(MAX_COLS) : grid_cols_reg;
        cfg.start_row = COORD_W'(start_row_reg);
        cfg.start_col = COORD_W'(start_col_reg);
        cfg.goal_row  = COORD_W'(goal_row_reg);
        cfg.goal_col  = COORD_W'(goal_col_reg);
    end

    // Input unpacking and acceptance.
    assign cmd.mode     = mode_t'(s_tdata[1:0]);
    assign cmd.row      = s_tdata[6:2];
    assign cmd.col      = s_tdata[11:7];
    assign cmd.obstacle = s_tdata[12];
    assign s_tready     = core_idle && (!m_tvalid_reg || m_tready);
    assign cmd_valid    = s_tvalid && s_tready;

    gas_core #(
        .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .OPEN_DEPTH(OPEN_DEPTH)
    ) u_core (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .cmd_valid(cmd_valid), .cmd(cmd),
        .idle(core_idle), .res_valid(res_valid), .res(res)
    );

    // Output register holds a result until its transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_res_reg.searched, m_res_reg.path_found, m_res_reg.cell_state};

endmodule
